// ----- rtl/trc_pkg.sv -----
package trc_pkg;

   // window storage geometry
   localparam int WindowDepth = 64;
   localparam int PTR_W       = $clog2(WindowDepth);
   localparam int FILL_W      = $clog2(WindowDepth + 1);
   localparam int NUM_CNT     = 6;
   localparam int NUM_RATE    = 9;
   localparam int SUB_W       = 4;
   localparam int ADDR_W      = PTR_W + SUB_W;
   localparam int WLEN_W      = 7;
   localparam int CMP_W       = (FILL_W > WLEN_W) ? FILL_W : WLEN_W;
   localparam int ACC_W       = 98;

   // register indexes
   localparam logic [7:0] REG_DISK_MODE   = 8'd0;
   localparam logic [7:0] REG_WRAP_LIMIT  = 8'd1;
   localparam logic [7:0] REG_WINDOW_LEN  = 8'd2;
   localparam logic [7:0] REG_PRIME_FIRST = 8'd3;

   // rate kinds within a class
   localparam logic [1:0] KIND_IN    = 2'd0;
   localparam logic [1:0] KIND_OUT   = 2'd1;
   localparam logic [1:0] KIND_TOTAL = 2'd2;

   typedef struct packed {
      logic [63:0] bytes_in;
      logic [63:0] bytes_out;
      logic [63:0] packets_in;
      logic [63:0] packets_out;
      logic [63:0] errors_in;
      logic [63:0] errors_out;
      logic [31:0] rate_scale;
   } req_type;

   typedef struct packed {
      logic [63:0]       delta_in;
      logic [63:0]       delta_out;
      logic [63:0]       max_in;
      logic [63:0]       max_out;
      logic [63:0]       max_total;
      logic [63:0]       sum_in;
      logic [63:0]       sum_out;
      logic [63:0]       win_in;
      logic [63:0]       win_out;
      logic [63:0]       win_total;
      logic [WLEN_W-1:0] win_count;
      logic              last;
   } rsp_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DELTA = 8'b0000_0010,
      ST_DISK  = 8'b0000_0100,
      ST_RATE  = 8'b0000_1000,
      ST_POP   = 8'b0001_0000,
      ST_PUSH  = 8'b0010_0000,
      ST_TRIM  = 8'b0100_0000,
      ST_SEND  = 8'b1000_0000
   } state_type;

   // class of rate index 0..8
   function automatic logic [1:0] rate_class(input logic [SUB_W-1:0] idx);
      logic [1:0] c;
      unique case (idx)
         4'd0, 4'd1, 4'd2: c = 2'd0;
         4'd3, 4'd4, 4'd5: c = 2'd1;
         default:          c = 2'd2;
      endcase
      return c;
   endfunction

   // kind of rate index 0..8
   function automatic logic [1:0] rate_kind(input logic [SUB_W-1:0] idx);
      logic [1:0] k;
      unique case (idx)
         4'd0, 4'd3, 4'd6: k = KIND_IN;
         4'd1, 4'd4, 4'd7: k = KIND_OUT;
         default:          k = KIND_TOTAL;
      endcase
      return k;
   endfunction

   // first rate index of a class
   function automatic logic [SUB_W-1:0] rate_base(input logic [1:0] c);
      logic [SUB_W-1:0] b;
      unique case (c)
         2'd0:    b = 4'd0;
         2'd1:    b = 4'd3;
         default: b = 4'd6;
      endcase
      return b;
   endfunction

endpackage

// ----- rtl/traffic_counter_rate_stats.sv -----
// Flow: from accept, six deltas, nine scaled rates on the shared 32x32 multiplier, nine
// window writes and a trim check, plus a product step in disk mode; a full window first
// drops its oldest sample, and the window pops one sample at a time when it shrinks.
// Throughput: one snapshot at a time, answered in three beats; req_ready is high only
// while idle.
// Reset: synchronous, active high; clears statistics and window pointers, sets configuration defaults.
module traffic_counter_rate_stats (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  trc_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output trc_pkg::rsp_type   rsp_data,
   input  logic               csr_we,
   input  logic [7:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   // configuration
   logic                       cfg_disk_ff;
   logic [63:0]                cfg_wrap_ff;
   logic [trc_pkg::WLEN_W-1:0] cfg_wlen_ff;
   logic                       cfg_prime_ff;

   // control
   trc_pkg::state_type          state_ff, state_in;
   logic [trc_pkg::SUB_W-1:0]   sub_ff, sub_in;
   logic [trc_pkg::SUB_W-1:0]   idx_ff, idx_in;
   logic [1:0]                  beat_ff, beat_in;
   logic                        pop_push_ff, pop_push_in;
   logic                        primed_ff, primed_in;
   logic [trc_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [trc_pkg::FILL_W-1:0]  fill_ff, fill_in;

   // statistics
   logic [63:0] prev_ff [trc_pkg::NUM_CNT];
   logic [63:0] prev_in [trc_pkg::NUM_CNT];
   logic [63:0] dsum_ff [trc_pkg::NUM_CNT];
   logic [63:0] dsum_in [trc_pkg::NUM_CNT];
   logic [63:0] max_ff  [trc_pkg::NUM_RATE];
   logic [63:0] max_in  [trc_pkg::NUM_RATE];
   logic [63:0] wsum_ff [trc_pkg::NUM_RATE];
   logic [63:0] wsum_in [trc_pkg::NUM_RATE];

   // working payload
   trc_pkg::req_type            req_ff, req_in;
   logic [63:0]                 delta_ff [trc_pkg::NUM_CNT];
   logic [63:0]                 delta_in [trc_pkg::NUM_CNT];
   logic [63:0]                 rate_ff  [trc_pkg::NUM_RATE];
   logic [63:0]                 rate_in  [trc_pkg::NUM_RATE];
   logic [64:0]                 x_ff, x_in;
   logic [trc_pkg::ACC_W-1:0]   acc_ff, acc_in;

   // window memory
   logic [63:0]                 win_mem [2**trc_pkg::ADDR_W];
   logic [63:0]                 rd_ff;
   logic                        mem_we;
   logic [trc_pkg::ADDR_W-1:0]  mem_waddr;
   logic [trc_pkg::ADDR_W-1:0]  mem_raddr;
   logic [63:0]                 mem_wdata;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] prod;

   trc_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   function automatic logic [63:0] cnt_of(input trc_pkg::req_type r, input logic [2:0] i);
      logic [63:0] v;
      unique case (i)
         3'd0:    v = r.bytes_in;
         3'd1:    v = r.bytes_out;
         3'd2:    v = r.packets_in;
         3'd3:    v = r.packets_out;
         3'd4:    v = r.errors_in;
         default: v = r.errors_out;
      endcase
      return v;
   endfunction

   logic [1:0]                 cls, knd;
   logic [2:0]                 d_idx;
   logic [63:0]                now_cnt, before_cnt, disk_a, rate_val;
   logic [trc_pkg::CMP_W-1:0]  limit, fill_ext;
   logic [trc_pkg::PTR_W-1:0]  slot;

   assign cls        = trc_pkg::rate_class(idx_ff);
   assign knd        = trc_pkg::rate_kind(idx_ff);
   assign d_idx      = {cls, 1'b0} + {1'b0, knd};
   assign now_cnt    = cnt_of(req_ff, idx_ff[2:0]);
   assign before_cnt = (cfg_prime_ff && !primed_ff) ? now_cnt : prev_ff[idx_ff[2:0]];
   assign disk_a     = delta_ff[3'd2 + {2'd0, idx_ff[0]}];
   assign rate_val   = (|acc_ff[trc_pkg::ACC_W-1:80]) ? '1 : acc_ff[79:16];
   assign fill_ext   = trc_pkg::CMP_W'(fill_ff);
   assign slot       = head_ff + fill_ff[trc_pkg::PTR_W-1:0];

   // window length limited to 1..depth
   always_comb begin
      if (cfg_wlen_ff == '0) begin
         limit = trc_pkg::CMP_W'(1);
      end else if (trc_pkg::CMP_W'(cfg_wlen_ff) > trc_pkg::CMP_W'(trc_pkg::WindowDepth)) begin
         limit = trc_pkg::CMP_W'(trc_pkg::WindowDepth);
      end else begin
         limit = trc_pkg::CMP_W'(cfg_wlen_ff);
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      sub_in      = sub_ff;
      idx_in      = idx_ff;
      beat_in     = beat_ff;
      pop_push_in = pop_push_ff;
      primed_in   = primed_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      prev_in     = prev_ff;
      dsum_in     = dsum_ff;
      max_in      = max_ff;
      wsum_in     = wsum_ff;
      req_in      = req_ff;
      delta_in    = delta_ff;
      rate_in     = rate_ff;
      x_in        = x_ff;
      acc_in      = acc_ff;
      mul_a       = '0;
      mul_b       = '0;
      mem_we      = 1'b0;
      mem_waddr   = {slot, sub_ff};
      mem_wdata   = rate_ff[sub_ff];
      mem_raddr   = {head_ff, sub_ff};

      unique case (state_ff)
         trc_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               state_in = trc_pkg::ST_DELTA;
               idx_in   = '0;
               sub_in   = '0;
            end
         end

         // difference with borrow, then wrap correction
         trc_pkg::ST_DELTA: begin
            if (sub_ff == '0) begin
               x_in   = {1'b0, now_cnt} - {1'b0, before_cnt};
               sub_in = 4'd1;
            end else begin
               delta_in[idx_ff[2:0]] = x_ff[64] ? cfg_wrap_ff + x_ff[63:0] : x_ff[63:0];
               sub_in = '0;
               if (idx_ff == 4'd5) begin
                  idx_in   = '0;
                  state_in = cfg_disk_ff ? trc_pkg::ST_DISK : trc_pkg::ST_RATE;
               end else begin
                  idx_in = idx_ff + 4'd1;
               end
            end
         end

         // packets * (errors + 1), low 64 bits from three partial products
         trc_pkg::ST_DISK: begin
            sub_in = sub_ff + 4'd1;
            unique case (sub_ff)
               4'd0: x_in = {1'b0, delta_ff[3'd4 + {2'd0, idx_ff[0]}] + 64'd1};
               4'd1: begin
                  mul_a = disk_a[31:0];
                  mul_b = x_ff[31:0];
               end
               4'd2: begin
                  acc_in = trc_pkg::ACC_W'(prod);
                  mul_a  = disk_a[31:0];
                  mul_b  = x_ff[63:32];
               end
               4'd3: begin
                  acc_in = acc_ff + trc_pkg::ACC_W'({prod, 32'd0});
                  mul_a  = disk_a[63:32];
                  mul_b  = x_ff[31:0];
               end
               4'd4: acc_in = acc_ff + trc_pkg::ACC_W'({prod, 32'd0});
               default: begin
                  delta_in[3'd2 + {2'd0, idx_ff[0]}] = acc_ff[63:0];
                  sub_in = '0;
                  if (idx_ff[0]) begin
                     delta_in[4] = '0;
                     delta_in[5] = '0;
                     idx_in      = '0;
                     state_in    = trc_pkg::ST_RATE;
                  end else begin
                     idx_in = 4'd1;
                  end
               end
            endcase
         end

         // scaled rate, max and delta sums
         trc_pkg::ST_RATE: begin
            sub_in = sub_ff + 4'd1;
            unique case (sub_ff)
               4'd0: begin
                  priority case (knd)
                     trc_pkg::KIND_IN:  x_in = {1'b0, delta_ff[{cls, 1'b0}]};
                     trc_pkg::KIND_OUT: x_in = {1'b0, delta_ff[{cls, 1'b1}]};
                     default: x_in = {1'b0, delta_ff[{cls, 1'b0}]}
                                   + {1'b0, delta_ff[{cls, 1'b1}]};
                  endcase
               end
               4'd1: begin
                  mul_a = x_ff[31:0];
                  mul_b = req_ff.rate_scale;
               end
               4'd2: begin
                  acc_in = trc_pkg::ACC_W'(prod);
                  mul_a  = x_ff[63:32];
                  mul_b  = req_ff.rate_scale;
               end
               4'd3: begin
                  acc_in = acc_ff + trc_pkg::ACC_W'({prod, 32'd0})
                         + (x_ff[64] ? trc_pkg::ACC_W'({req_ff.rate_scale, 64'd0})
                                     : trc_pkg::ACC_W'(0));
               end
               default: begin
                  rate_in[idx_ff] = rate_val;
                  if (rate_val > max_ff[idx_ff]) begin
                     max_in[idx_ff] = rate_val;
                  end
                  if (knd != trc_pkg::KIND_TOTAL) begin
                     dsum_in[d_idx] = dsum_ff[d_idx] + x_ff[63:0];
                  end
                  sub_in = '0;
                  if (idx_ff == 4'd8) begin
                     idx_in = '0;
                     if (fill_ext == trc_pkg::CMP_W'(trc_pkg::WindowDepth)) begin
                        pop_push_in = 1'b1;
                        state_in    = trc_pkg::ST_POP;
                     end else begin
                        state_in = trc_pkg::ST_PUSH;
                     end
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
            endcase
         end

         // drop oldest sample: read issue runs one step ahead of the subtract
         trc_pkg::ST_POP: begin
            if (sub_ff != '0) begin
               wsum_in[sub_ff - 4'd1] = wsum_ff[sub_ff - 4'd1] - rd_ff;
            end
            if (sub_ff == 4'd9) begin
               head_in  = head_ff + 1'b1;
               fill_in  = fill_ff - 1'b1;
               sub_in   = '0;
               state_in = pop_push_ff ? trc_pkg::ST_PUSH : trc_pkg::ST_TRIM;
               pop_push_in = 1'b0;
            end else begin
               sub_in = sub_ff + 4'd1;
            end
         end

         // store newest sample
         trc_pkg::ST_PUSH: begin
            mem_we          = 1'b1;
            wsum_in[sub_ff] = wsum_ff[sub_ff] + rate_ff[sub_ff];
            if (sub_ff == 4'd8) begin
               fill_in  = fill_ff + 1'b1;
               sub_in   = '0;
               state_in = trc_pkg::ST_TRIM;
            end else begin
               sub_in = sub_ff + 4'd1;
            end
         end

         trc_pkg::ST_TRIM: begin
            if (fill_ext > trc_pkg::CMP_W'(1) && fill_ext > limit) begin
               sub_in      = '0;
               pop_push_in = 1'b0;
               state_in    = trc_pkg::ST_POP;
            end else begin
               for (int i = 0; i < trc_pkg::NUM_CNT; i++) begin
                  prev_in[i] = cnt_of(req_ff, 3'(i));
               end
               primed_in = 1'b1;
               beat_in   = '0;
               state_in  = trc_pkg::ST_SEND;
            end
         end

         trc_pkg::ST_SEND: begin
            if (rsp_ready) begin
               if (beat_ff == 2'd2) begin
                  state_in = trc_pkg::ST_IDLE;
               end else begin
                  beat_in = beat_ff + 2'd1;
               end
            end
         end

         default: state_in = trc_pkg::ST_IDLE;
      endcase
   end

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= trc_pkg::ST_IDLE;
         sub_ff       <= '0;
         idx_ff       <= '0;
         beat_ff      <= '0;
         pop_push_ff  <= 1'b0;
         primed_ff    <= 1'b0;
         head_ff      <= '0;
         fill_ff      <= '0;
         cfg_disk_ff  <= 1'b0;
         cfg_wrap_ff  <= 64'hFFFF_FFFF;
         cfg_wlen_ff  <= 7'd8;
         cfg_prime_ff <= 1'b1;
         for (int i = 0; i < trc_pkg::NUM_CNT; i++) begin
            prev_ff[i] <= '0;
            dsum_ff[i] <= '0;
         end
         for (int i = 0; i < trc_pkg::NUM_RATE; i++) begin
            max_ff[i]  <= '0;
            wsum_ff[i] <= '0;
         end
      end else begin
         state_ff    <= state_in;
         sub_ff      <= sub_in;
         idx_ff      <= idx_in;
         beat_ff     <= beat_in;
         pop_push_ff <= pop_push_in;
         primed_ff   <= primed_in;
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         prev_ff     <= prev_in;
         dsum_ff     <= dsum_in;
         max_ff      <= max_in;
         wsum_ff     <= wsum_in;
         if (csr_we) begin
            unique case (csr_index)
               trc_pkg::REG_DISK_MODE:   cfg_disk_ff  <= csr_wdata[0];
               trc_pkg::REG_WRAP_LIMIT:  cfg_wrap_ff  <= csr_wdata;
               trc_pkg::REG_WINDOW_LEN:  cfg_wlen_ff  <= csr_wdata[trc_pkg::WLEN_W-1:0];
               trc_pkg::REG_PRIME_FIRST: cfg_prime_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // working payload, no reset
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      delta_ff <= delta_in;
      rate_ff  <= rate_in;
      x_ff     <= x_in;
      acc_ff   <= acc_in;
   end

   // window memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         win_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= win_mem[mem_raddr];
   end

   // result beats, one per class
   logic [trc_pkg::SUB_W-1:0] rb;
   assign rb = trc_pkg::rate_base(beat_ff);

   assign req_ready = (state_ff == trc_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == trc_pkg::ST_SEND);

   always_comb begin
      rsp_data.delta_in  = delta_ff[{beat_ff, 1'b0}];
      rsp_data.delta_out = delta_ff[{beat_ff, 1'b1}];
      rsp_data.max_in    = max_ff[rb];
      rsp_data.max_out   = max_ff[rb + 4'd1];
      rsp_data.max_total = max_ff[rb + 4'd2];
      rsp_data.sum_in    = dsum_ff[{beat_ff, 1'b0}];
      rsp_data.sum_out   = dsum_ff[{beat_ff, 1'b1}];
      rsp_data.win_in    = wsum_ff[rb];
      rsp_data.win_out   = wsum_ff[rb + 4'd1];
      rsp_data.win_total = wsum_ff[rb + 4'd2];
      rsp_data.win_count = trc_pkg::WLEN_W'(fill_ff);
      rsp_data.last      = (beat_ff == 2'd2);
   end

endmodule

// ----- rtl/trc_mul.sv -----
// shared 32x32 multiplier, product registered
module trc_mul (
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] prod
);

   logic [63:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= {32'd0, mul_a} * {32'd0, mul_b};
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/trc_check.sv -----
module trc_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input trc_pkg::rsp_type rsp_data
);

   // no new snapshot while results are pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("req_ready high while results pending");

   // an accepted snapshot blocks the input and does not answer at once
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (!req_ready && !rsp_valid))
      else $error("block not busy after accept");

   // beats of one snapshot follow back to back
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |=> rsp_valid)
      else $error("gap inside result burst");

   // last beat returns the block to idle
   a_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last) |=> (!rsp_valid && req_ready))
      else $error("block not idle after last beat");

   // window always holds the newest sample
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.win_count != '0))
      else $error("empty window reported");

endmodule

bind traffic_counter_rate_stats trc_check u_trc_check (.*);

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

   localparam int         STALL_LIMIT = 4000;
   localparam logic [7:0] REG_UNUSED  = 8'd9;
   localparam logic [63:0] ONES64     = 64'hFFFF_FFFF_FFFF_FFFF;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   trc_pkg::req_type   req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   trc_pkg::rsp_type   rsp_data;
   logic               csr_we = 1'b0;
   logic [7:0]         csr_index = '0;
   logic [63:0]        csr_wdata = '0;

   traffic_counter_rate_stats dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow configuration and statistics state
   logic          cfg_disk;
   logic [63:0]   cfg_wrap;
   logic [6:0]    cfg_wlen;
   logic          cfg_prime;
   logic [63:0]   prev_cnt [6];
   logic          primed;
   logic [63:0]   peak_rate [9];
   logic [63:0]   delta_total [6];
   logic [63:0]   ring_sum [9];
   logic [63:0]   ring_rate [64][9];
   logic [5:0]    ring_head;
   logic [6:0]    ring_fill;

   trc_pkg::rsp_type expected_beats [$];
   logic [63:0]   last_cnt [6];
   int            send_idle_pct = 0;
   int            stall_pct = 0;
   int            mismatches = 0;
   int            snapshots = 0;
   int            beats_seen = 0;
   int            idle_count = 0;

   // (value * scale) >> 16, saturated to 64 bits
   function automatic logic [63:0] scale_rate(input logic [64:0] v, input logic [31:0] s);
      logic [96:0] p;
      p = {32'b0, v} * {65'b0, s};
      if (p[96:80] != '0) return ONES64;
      return p[79:16];
   endfunction

   function automatic logic [63:0] counter_delta(input logic [63:0] now, input logic [63:0] old);
      if (now >= old) return now - old;
      return (cfg_wrap - old) + now;
   endfunction

   task automatic ring_pop();
      for (int k = 0; k < 9; k++) ring_sum[k] = ring_sum[k] - ring_rate[ring_head][k];
      ring_head = ring_head + 6'd1;
      ring_fill = ring_fill - 7'd1;
   endtask

   // updates the shadow statistics for one snapshot and queues its three beats
   task automatic predict_stats(input trc_pkg::req_type r);
      logic [63:0] cnt [6];
      logic [63:0] d [6];
      logic [63:0] rate [9];
      logic [64:0] tot;
      logic [6:0]  lim;
      logic [5:0]  slot;
      trc_pkg::rsp_type b;
      cnt = '{r.bytes_in, r.bytes_out, r.packets_in, r.packets_out, r.errors_in, r.errors_out};
      for (int i = 0; i < 6; i++)
         d[i] = counter_delta(cnt[i], (cfg_prime && !primed) ? cnt[i] : prev_cnt[i]);
      if (cfg_disk) begin
         d[2] = d[2] * (d[4] + 64'd1);
         d[3] = d[3] * (d[5] + 64'd1);
         d[4] = '0;
         d[5] = '0;
      end
      for (int c = 0; c < 3; c++) begin
         tot = {1'b0, d[2*c]} + {1'b0, d[2*c+1]};
         rate[3*c]   = scale_rate({1'b0, d[2*c]}, r.rate_scale);
         rate[3*c+1] = scale_rate({1'b0, d[2*c+1]}, r.rate_scale);
         rate[3*c+2] = scale_rate(tot, r.rate_scale);
         for (int k = 0; k < 3; k++)
            if (rate[3*c+k] > peak_rate[3*c+k]) peak_rate[3*c+k] = rate[3*c+k];
         delta_total[2*c]   = delta_total[2*c] + d[2*c];
         delta_total[2*c+1] = delta_total[2*c+1] + d[2*c+1];
      end
      // sliding window: push newest, trim to length
      lim = (cfg_wlen < 7'd1) ? 7'd1 : (cfg_wlen > 7'd64) ? 7'd64 : cfg_wlen;
      if (ring_fill >= 7'd64) ring_pop();
      slot = ring_head + ring_fill[5:0];
      for (int k = 0; k < 9; k++) begin
         ring_rate[slot][k] = rate[k];
         ring_sum[k] = ring_sum[k] + rate[k];
      end
      ring_fill = ring_fill + 7'd1;
      while (ring_fill > 7'd1 && ring_fill > lim) ring_pop();
      prev_cnt = cnt;
      primed = 1'b1;
      for (int c = 0; c < 3; c++) begin
         b.delta_in  = d[2*c];
         b.delta_out = d[2*c+1];
         b.max_in    = peak_rate[3*c];
         b.max_out   = peak_rate[3*c+1];
         b.max_total = peak_rate[3*c+2];
         b.sum_in    = delta_total[2*c];
         b.sum_out   = delta_total[2*c+1];
         b.win_in    = ring_sum[3*c];
         b.win_out   = ring_sum[3*c+1];
         b.win_total = ring_sum[3*c+2];
         b.win_count = ring_fill;
         b.last      = (c == 2);
         expected_beats.push_back(b);
      end
   endtask

   // result beat checking and receiver stalls
   always @(posedge clock) begin
      trc_pkg::rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_seen++;
         if (expected_beats.size() == 0) begin
            $error("unexpected result beat");
            mismatches++;
         end else begin
            e = expected_beats.pop_front();
            if (rsp_data.delta_in !== e.delta_in) begin
               $error("delta_in exp %h got %h", e.delta_in, rsp_data.delta_in); mismatches++;
            end
            if (rsp_data.delta_out !== e.delta_out) begin
               $error("delta_out exp %h got %h", e.delta_out, rsp_data.delta_out); mismatches++;
            end
            if (rsp_data.max_in !== e.max_in) begin
               $error("max_in exp %h got %h", e.max_in, rsp_data.max_in); mismatches++;
            end
            if (rsp_data.max_out !== e.max_out) begin
               $error("max_out exp %h got %h", e.max_out, rsp_data.max_out); mismatches++;
            end
            if (rsp_data.max_total !== e.max_total) begin
               $error("max_total exp %h got %h", e.max_total, rsp_data.max_total); mismatches++;
            end
            if (rsp_data.sum_in !== e.sum_in) begin
               $error("sum_in exp %h got %h", e.sum_in, rsp_data.sum_in); mismatches++;
            end
            if (rsp_data.sum_out !== e.sum_out) begin
               $error("sum_out exp %h got %h", e.sum_out, rsp_data.sum_out); mismatches++;
            end
            if (rsp_data.win_in !== e.win_in) begin
               $error("win_in exp %h got %h", e.win_in, rsp_data.win_in); mismatches++;
            end
            if (rsp_data.win_out !== e.win_out) begin
               $error("win_out exp %h got %h", e.win_out, rsp_data.win_out); mismatches++;
            end
            if (rsp_data.win_total !== e.win_total) begin
               $error("win_total exp %h got %h", e.win_total, rsp_data.win_total); mismatches++;
            end
            if (rsp_data.win_count !== e.win_count) begin
               $error("win_count exp %0d got %0d", e.win_count, rsp_data.win_count); mismatches++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0b got %0b", e.last, rsp_data.last); mismatches++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog on cycles with no beat in either direction
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) begin
         idle_count <= 0;
      end else if (idle_count >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   task automatic wait_drained();
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] idx, input logic [63:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         trc_pkg::REG_DISK_MODE:   cfg_disk  = val[0];
         trc_pkg::REG_WRAP_LIMIT:  cfg_wrap  = val;
         trc_pkg::REG_WINDOW_LEN:  cfg_wlen  = val[6:0];
         trc_pkg::REG_PRIME_FIRST: cfg_prime = val[0];
         default: ;
      endcase
   endtask

   // register settings applied between phases, only with the block drained
   task automatic apply_setup(input int n);
      wait_drained();
      case (n)
         1: begin
            write_reg(trc_pkg::REG_DISK_MODE, 64'd1);
            write_reg(trc_pkg::REG_WRAP_LIMIT, ONES64);
            write_reg(trc_pkg::REG_WINDOW_LEN, 64'd1);
            write_reg(trc_pkg::REG_PRIME_FIRST, 64'd0);
         end
         2: begin
            write_reg(trc_pkg::REG_DISK_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
            write_reg(trc_pkg::REG_WRAP_LIMIT, 64'd0);
            write_reg(trc_pkg::REG_WINDOW_LEN, 64'd0);
            write_reg(REG_UNUSED, ONES64);
         end
         3: begin
            write_reg(trc_pkg::REG_WINDOW_LEN, 64'hFF);
            write_reg(trc_pkg::REG_PRIME_FIRST, 64'd1);
            write_reg(trc_pkg::REG_WRAP_LIMIT, {$urandom, $urandom});
         end
         4: begin
            write_reg(trc_pkg::REG_WINDOW_LEN, 64'd3);
            write_reg(trc_pkg::REG_DISK_MODE, 64'd1);
         end
         5: begin
            write_reg(trc_pkg::REG_WINDOW_LEN, 64'd64);
            write_reg(trc_pkg::REG_DISK_MODE, 64'd0);
            write_reg(trc_pkg::REG_WRAP_LIMIT, 64'hFFFF_FFFF);
         end
         default: begin
            write_reg(trc_pkg::REG_WINDOW_LEN, 64'd5);
            write_reg(trc_pkg::REG_PRIME_FIRST, 64'd0);
         end
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // one snapshot beat with an optional leading gap
   task automatic send_snapshot(input trc_pkg::req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      predict_stats(r);
      snapshots++;
   endtask

   // mostly counters that climb from the last snapshot, some that drop back, some raw noise
   function automatic trc_pkg::req_type make_snapshot();
      trc_pkg::req_type r;
      logic [63:0]      c [6];
      int               kind;
      kind = $urandom_range(99);
      for (int i = 0; i < 6; i++) begin
         if (kind < 75)
            c[i] = last_cnt[i] + ((i >= 4) ? $urandom_range(0, 3) : $urandom_range(0, 200000));
         else if (kind < 85)
            c[i] = last_cnt[i] - $urandom_range(0, 1000);
         else
            c[i] = {$urandom, $urandom};
         last_cnt[i] = c[i];
      end
      r.bytes_in    = c[0];
      r.bytes_out   = c[1];
      r.packets_in  = c[2];
      r.packets_out = c[3];
      r.errors_in   = c[4];
      r.errors_out  = c[5];
      case ($urandom_range(3))
         0: r.rate_scale = 32'h0001_0000;
         1: r.rate_scale = $urandom_range(0, 32'h0004_0000);
         default: r.rate_scale = $urandom;
      endcase
      return r;
   endfunction

   typedef struct {
      int               setup;
      trc_pkg::req_type snap;
      bit               known;
      trc_pkg::rsp_type first_beat;
   } row_type;

   localparam trc_pkg::rsp_type PRIMED_ZERO = '{default: '0, win_count: 7'd1, last: 1'b0};

   row_type stim_rows [] = '{
      '{0, '{64'd1000, 64'd2000, 64'd10, 64'd20, 64'd1, 64'd2, 32'h0001_0000},
        1'b1, PRIMED_ZERO},
      '{0, '{64'd5000, 64'd9000, 64'd50, 64'd70, 64'd3, 64'd3, 32'h0001_0000}, 1'b0, '0},
      '{0, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'h0002_8000}, 1'b0, '0},
      '{0, '{ONES64, ONES64, ONES64, ONES64, ONES64, ONES64, 32'hFFFF_FFFF}, 1'b0, '0},
      '{0, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'h0000_0000}, 1'b0, '0},
      '{0, '{64'd777, 64'd1, 64'd3, 64'd4, 64'd5, 64'd6, 32'h0000_0001}, 1'b0, '0},
      '{1, '{64'd100, 64'd200, 64'd30, 64'd40, 64'd2, 64'd9, 32'h0001_0000}, 1'b0, '0},
      '{0, '{ONES64, ONES64, ONES64, ONES64, ONES64, ONES64, 32'hFFFF_FFFF}, 1'b0, '0},
      '{0, '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 32'h8000_0000}, 1'b0, '0},
      '{0, '{64'h8000_0000_0000_0000, 64'd5, 64'h1_0000_0000, 64'd7, 64'hFFFF, 64'd1,
             32'h0001_0000}, 1'b0, '0},
      '{2, '{64'd10, 64'd20, 64'd30, 64'd40, 64'd50, 64'd60, 32'h0001_0000}, 1'b0, '0},
      '{0, '{64'd5, 64'd25, 64'd35, 64'd10, 64'd50, 64'd61, 32'h0003_0000}, 1'b0, '0},
      '{0, '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'd1, 64'd2, 64'd3,
             64'd4, 32'hFFFF_FFFF}, 1'b0, '0}
   };

   initial begin
      cfg_disk = 1'b0; cfg_wrap = 64'hFFFF_FFFF; cfg_wlen = 7'd8; cfg_prime = 1'b1;
      prev_cnt = '{default: '0}; primed = 1'b0;
      peak_rate = '{default: '0}; delta_total = '{default: '0}; ring_sum = '{default: '0};
      ring_head = '0; ring_fill = '0;
      last_cnt = '{default: '0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; the first row is the primed snapshot with zero deltas
      foreach (stim_rows[i]) begin
         if (stim_rows[i].setup != 0) begin
            req_valid <= 1'b0;
            apply_setup(stim_rows[i].setup);
         end
         send_snapshot(stim_rows[i].snap);
         if (stim_rows[i].known)
            expected_beats[expected_beats.size() - 3] = stim_rows[i].first_beat;
      end
      req_valid <= 1'b0;

      // random phases under each idling mode
      for (int p = 0; p < 4; p++) begin
         apply_setup(3 + p);
         case (p)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 56; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 56; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         for (int n = 0; n < ((p == 0) ? 70 : 33); n++) send_snapshot(make_snapshot());
         req_valid <= 1'b0;
      end

      while (expected_beats.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Checked %0d snapshots and %0d result beats across network and disk rules,",
               snapshots, beats_seen);
      $display("window lengths 0 to 127 with shrink, wrap limits and saturating scales.");
      if (mismatches == 0 && expected_beats.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
